@@ hw/rtl/wsd_pkg.sv @@
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

  // Frame parsing phase
  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  // Second header byte fields
  localparam int unsigned MASK_BIT = 7;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Byte counts of the extended length and key fields
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // One result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_frame;
    logic       empty_frame;
  } result_t;

endpackage

@@ hw/rtl/wsd_rx_if.sv @@
// Received byte stream channel.
interface wsd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

@@ hw/rtl/wsd_pl_if.sv @@
// Unmasked payload result channel.
interface wsd_pl_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_frame;
  logic       empty_frame;

  modport source (output valid, output out_byte, output last_of_frame,
                  output empty_frame, input ready);
  modport sink   (input valid, input out_byte, input last_of_frame,
                  input empty_frame, output ready);
endinterface

@@ hw/rtl/wsd_in_reg.sv @@
// Input register stage: holds one received byte until the parser consumes it.
module wsd_in_reg
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  wsd_rx_if.sink     rx,
  input  logic       go,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  // Free when empty or when the held beat moves on this cycle
  assign rx.ready = !hold_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (rx.ready) begin
      hold_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      hold_byte <= rx.in_byte;
    end
  end

endmodule

@@ hw/rtl/wsd_parser.sv @@
// Frame header parser and payload unmasking with the per-frame state.
module wsd_parser
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic [7:0] in_byte,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase, phase_next;
  logic [3:0]  ext_count, ext_count_next;
  logic [63:0] remaining_length, remaining_length_next;
  logic        key_present, key_present_next;
  logic [31:0] key_bytes, key_bytes_next;
  logic [1:0]  key_index, key_index_next;

  // Shared datapath terms
  logic [6:0]  hdr_len;
  logic        hdr_ext;
  logic [3:0]  ext_dec;
  logic [63:0] rem_dec;
  logic [63:0] rem_shift;
  logic [7:0]  key_byte;

  assign hdr_len   = in_byte[6:0];
  assign hdr_ext   = (hdr_len == LEN_EXT16) || (hdr_len == LEN_EXT64);
  assign ext_dec   = ext_count - 4'd1;
  assign rem_dec   = remaining_length - 64'd1;
  assign rem_shift = {remaining_length[55:0], in_byte};

  // Key byte at the payload offset, first key byte in the top lane
  always_comb begin
    case (key_index)
      2'd0:    key_byte = key_bytes[31:24];
      2'd1:    key_byte = key_bytes[23:16];
      2'd2:    key_byte = key_bytes[15:8];
      default: key_byte = key_bytes[7:0];
    endcase
  end

  // Next state
  always_comb begin
    phase_next            = phase;
    ext_count_next        = ext_count;
    remaining_length_next = remaining_length;
    key_present_next      = key_present;
    key_bytes_next        = key_bytes;
    key_index_next        = key_index;
    unique case (phase)
      PH_HDR1: begin
        key_present_next = in_byte[MASK_BIT];
        key_index_next   = 2'd0;
        if (hdr_ext) begin
          remaining_length_next = 64'd0;
          phase_next            = PH_EXT;
          ext_count_next        = (hdr_len == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
        end else begin
          remaining_length_next = {57'd0, hdr_len};
          if (in_byte[MASK_BIT]) begin
            phase_next     = PH_KEY;
            ext_count_next = KEY_BYTES;
            key_bytes_next = 32'd0;
          end else begin
            phase_next = (hdr_len == 7'd0) ? PH_HDR0 : PH_DATA;
          end
        end
      end
      PH_EXT: begin
        remaining_length_next = rem_shift;
        ext_count_next        = ext_dec;
        if (ext_dec == 4'd0) begin
          if (key_present) begin
            phase_next     = PH_KEY;
            ext_count_next = KEY_BYTES;
            key_bytes_next = 32'd0;
          end else begin
            phase_next = (rem_shift == 64'd0) ? PH_HDR0 : PH_DATA;
          end
        end
      end
      PH_KEY: begin
        key_bytes_next = {key_bytes[23:0], in_byte};
        ext_count_next = ext_dec;
        if (ext_dec == 4'd0) begin
          phase_next = (remaining_length == 64'd0) ? PH_HDR0 : PH_DATA;
        end
      end
      PH_DATA: begin
        key_index_next        = key_index + 2'd1;
        remaining_length_next = rem_dec;
        if (rem_dec == 64'd0) begin
          phase_next = PH_HDR0;
        end
      end
      default: begin
        phase_next = PH_HDR1;
      end
    endcase
  end

  // Result for the current byte
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    unique case (phase)
      PH_HDR1: begin
        if (!hdr_ext && !in_byte[MASK_BIT] && hdr_len == 7'd0) begin
          res_valid         = 1'b1;
          res.last_of_frame = 1'b1;
          res.empty_frame   = 1'b1;
        end
      end
      PH_EXT: begin
        if (ext_dec == 4'd0 && !key_present && rem_shift == 64'd0) begin
          res_valid         = 1'b1;
          res.last_of_frame = 1'b1;
          res.empty_frame   = 1'b1;
        end
      end
      PH_KEY: begin
        if (ext_dec == 4'd0 && remaining_length == 64'd0) begin
          res_valid         = 1'b1;
          res.last_of_frame = 1'b1;
          res.empty_frame   = 1'b1;
        end
      end
      PH_DATA: begin
        res_valid         = 1'b1;
        res.out_byte      = key_present ? (in_byte ^ key_byte) : in_byte;
        res.last_of_frame = (rem_dec == 64'd0);
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HDR0;
      ext_count        <= 4'd0;
      remaining_length <= 64'd0;
      key_present      <= 1'b0;
      key_bytes        <= 32'd0;
      key_index        <= 2'd0;
    end else if (go) begin
      phase            <= phase_next;
      ext_count        <= ext_count_next;
      remaining_length <= remaining_length_next;
      key_present      <= key_present_next;
      key_bytes        <= key_bytes_next;
      key_index        <= key_index_next;
    end
  end

endmodule

@@ hw/rtl/wsd_out_reg.sv @@
// Result register driving the payload channel.
module wsd_out_reg
  import wsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  result_t  res,
  output logic     free,
  wsd_pl_if.source pl
);

  result_t held;

  // Room for a new beat when empty or when the held beat leaves now
  assign free = !pl.valid || pl.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pl.valid <= 1'b0;
    end else if (free) begin
      pl.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= res;
    end
  end

  assign pl.out_byte      = held.out_byte;
  assign pl.last_of_frame = held.last_of_frame;
  assign pl.empty_frame   = held.empty_frame;

endmodule

@@ hw/rtl/websocket_frame_deframer.sv @@
// Top level of the WebSocket frame deframer.
//
//   port  dir  payload                                  beat means
//   rx    in   in_byte[7:0]                             one received stream byte
//   pl    out  out_byte[7:0], last_of_frame, empty_frame  one payload byte or empty marker
//
// One byte per cycle sustained while pl does not stall: input register, header/unmask logic, result register.
// An rx beat passes the input register and then the result register to its pl beat; header bytes give no beat
// except when they close a zero-length frame.
// rst is synchronous and clears all frame state; the next byte is a first header byte.
// A stall on pl holds the byte in the input register and then back-pressures rx.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  wsd_rx_if.sink   rx,
  wsd_pl_if.source pl
);

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       res_valid;
  result_t    res;
  logic       free;
  logic       go;

  // A held byte moves on unless it has a result with nowhere to go
  assign go = hold_valid && (!res_valid || free);

  wsd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .go         (go),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .in_byte   (hold_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_reg u_out_reg (
    .clk  (clk),
    .rst  (rst),
    .load (go && res_valid),
    .res  (res),
    .free (free),
    .pl   (pl)
  );

endmodule

@@ test/wsd_deframer_checker.sv @@
// Watches the deframer channels, predicts every payload beat and checks what comes out.
module wsd_deframer_checker
  import wsd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  wsd_rx_if    rx,
  wsd_pl_if    pl,
  output int   fail_count,
  output int   results_due
);

  localparam int SHOWN_MAX = 10;
  localparam result_t EMPTY_MARKER = '{out_byte: 8'h00, last_of_frame: 1'b1, empty_frame: 1'b1};

  // Predicted frame state
  phase_t      ph         = PH_HDR0;
  logic [3:0]  field_left = '0;
  logic [63:0] bytes_left = '0;
  logic        masked     = 1'b0;
  logic [31:0] mask_key   = '0;
  logic [1:0]  key_pos    = '0;

  // Payload beats still owed by the block, oldest first
  result_t payload_due[$];

  int fails = 0;
  int shown = 0;

  initial begin
    fail_count  = 0;
    results_due = 0;
  end

  // Length known: go on to the key, to the payload, or close an empty frame
  function automatic void close_header();
    if (masked) begin
      ph         = PH_KEY;
      field_left = KEY_BYTES;
      mask_key   = '0;
    end else if (bytes_left == 64'd0) begin
      payload_due.push_back(EMPTY_MARKER);
      ph = PH_HDR0;
    end else begin
      ph = PH_DATA;
    end
  endfunction

  // Advance the predicted state by one received byte
  function automatic void deframe_byte(input logic [7:0] b);
    logic [7:0] k;
    case (ph)
      PH_HDR1: begin
        masked     = b[MASK_BIT];
        key_pos    = '0;
        bytes_left = '0;
        if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
          ph         = PH_EXT;
          field_left = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
        end else begin
          bytes_left = 64'(b[6:0]);
          close_header();
        end
      end
      PH_EXT: begin
        bytes_left = {bytes_left[55:0], b};
        field_left = field_left - 4'd1;
        if (field_left == 4'd0) close_header();
      end
      PH_KEY: begin
        mask_key   = {mask_key[23:0], b};
        field_left = field_left - 4'd1;
        if (field_left == 4'd0) begin
          if (bytes_left == 64'd0) begin
            payload_due.push_back(EMPTY_MARKER);
            ph = PH_HDR0;
          end else begin
            ph = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        // key byte by offset in the payload, first key byte in the top bits
        k          = masked ? 8'(mask_key >> (24 - 8 * key_pos)) : 8'h00;
        key_pos    = key_pos + 2'd1;
        bytes_left = bytes_left - 64'd1;
        payload_due.push_back('{b ^ k, bytes_left == 64'd0, 1'b0});
        if (bytes_left == 64'd0) ph = PH_HDR0;
      end
      default: ph = PH_HDR1;
    endcase
  endfunction

  // Compare each payload beat with the oldest prediction, then take in the rx beat
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst) begin
      ph         = PH_HDR0;
      field_left = '0;
      bytes_left = '0;
      masked     = 1'b0;
      mask_key   = '0;
      key_pos    = '0;
      payload_due.delete();
    end else begin
      if (pl.valid && pl.ready) begin
        seen = '{pl.out_byte, pl.last_of_frame, pl.empty_frame};
        if (payload_due.size() == 0) begin
          fails++;
          if (shown < SHOWN_MAX) begin
            shown++;
            $display("unexpected payload beat: byte %02h last %0b empty %0b",
                     seen.out_byte, seen.last_of_frame, seen.empty_frame);
          end
        end else begin
          want = payload_due.pop_front();
          if (seen !== want) begin
            fails++;
            if (shown < SHOWN_MAX) begin
              shown++;
              $display({"payload beat mismatch: expected byte %02h last %0b empty %0b,",
                        " got byte %02h last %0b empty %0b"},
                       want.out_byte, want.last_of_frame, want.empty_frame,
                       seen.out_byte, seen.last_of_frame, seen.empty_frame);
            end
          end
        end
      end
      if (rx.valid && rx.ready) deframe_byte(rx.in_byte);
    end
    fail_count  <= fails;
    results_due <= payload_due.size();
  end

endmodule

@@ test/websocket_frame_deframer_tb.sv @@
// Stimulus, back-pressure and verdict for the WebSocket frame deframer.
module websocket_frame_deframer_tb;
  import wsd_pkg::*;

  typedef enum {LEN7, LEN16, LEN64} len_form_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 4;
  localparam int PHASE_BYTES = 300;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_BYTES  = 20;
  // sender gap and receiver stall odds per phase, in percent
  localparam int GAP_PCT   [PHASES] = '{0, 61, 0, 26};
  localparam int STALL_PCT [PHASES] = '{0, 0, 61, 26};

  // Short frames: two-byte payload with extreme values, empty frames closed at the
  // second header byte, after a 16-bit length and after a key, then a masked frame
  // whose payload runs past the key once
  localparam logic [7:0] DIRECTED [27] = '{
    8'h81, 8'h02, 8'h00, 8'hFF,
    8'h82, 8'h00,
    8'hFF, 8'h7E, 8'h00, 8'h00,
    8'h00, 8'h80, 8'hFF, 8'h00, 8'hA5, 8'h5A,
    8'h01, 8'h85, 8'h12, 8'h34, 8'h56, 8'h78, 8'hFF, 8'h00, 8'h12, 8'h34, 8'hAB
  };

  logic clk;
  logic rst;
  int   fail_count;
  int   results_due;
  int   gap_pct    = 0;
  int   stall_pct  = 0;
  int   hold_reqs  = 0;
  int   bytes_sent = 0;
  int   cycles     = 0;

  wsd_rx_if rx ();
  wsd_pl_if pl ();

  websocket_frame_deframer dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .pl  (pl)
  );

  wsd_deframer_checker chk (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx),
    .pl          (pl),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    pl.ready   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        pl.ready <= 1'b0;
        hold_left--;
      end else if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        hold_left  = HOLD_CYCLES - 1;
        pl.ready  <= 1'b0;
      end else begin
        pl.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // One rx beat, after random gaps; valid stays high for a following byte
  task automatic put_byte(input logic [7:0] b);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      rx.valid <= 1'b0;
      @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.in_byte <= b;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Stop sending and wait until every predicted beat has come out
  task automatic drain();
    rx.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // One well-formed frame with random header, length form, key and payload
  task automatic send_frame();
    logic [7:0] frame_q[$];
    int         len;
    int         r;
    len_form_t  form;
    logic       is_masked;
    r = $urandom_range(99);
    if (r < 20)      len = 0;
    else if (r < 75) len = $urandom_range(12, 1);
    else if (r < 92) len = $urandom_range(40, 13);
    else if (r < 95) len = 125;
    else             len = $urandom_range(300, 126);
    // short lengths also go out in the longer forms, as stated non-minimally
    if (len > 125) begin
      form = ($urandom_range(3) == 0) ? LEN64 : LEN16;
    end else begin
      r    = $urandom_range(9);
      form = (r < 7) ? LEN7 : (r < 9) ? LEN16 : LEN64;
    end
    is_masked = 1'($urandom_range(1));
    frame_q.push_back(8'($urandom_range(255)));
    case (form)
      LEN7: frame_q.push_back({is_masked, 7'(len)});
      LEN16: begin
        frame_q.push_back({is_masked, LEN_EXT16});
        frame_q.push_back(8'(len >> 8));
        frame_q.push_back(8'(len));
      end
      default: begin
        frame_q.push_back({is_masked, LEN_EXT64});
        for (int i = 7; i >= 4; i--) frame_q.push_back(8'h00);
        for (int i = 3; i >= 0; i--) frame_q.push_back(8'(len >> (8 * i)));
      end
    endcase
    if (is_masked) begin
      for (int i = 0; i < 4; i++) frame_q.push_back(8'($urandom_range(255)));
    end
    for (int i = 0; i < len; i++) frame_q.push_back(8'($urandom_range(255)));
    foreach (frame_q[i]) put_byte(frame_q[i]);
  endtask

  // Main stimulus
  initial begin
    int phase_start;
    rst        = 1'b1;
    rx.valid   = 1'b0;
    rx.in_byte = 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) put_byte(DIRECTED[i]);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      gap_pct    = GAP_PCT[p];
      stall_pct <= STALL_PCT[p];
      // long hold-off while the sender keeps offering, so the block backs up
      if (p == 0) hold_reqs <= hold_reqs + 1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_frame();
      drain();
    end

    // Last frame: masked, 64-bit length with the top bit set, so it never closes
    gap_pct = 0;
    put_byte(8'($urandom_range(255)));
    put_byte({1'b1, LEN_EXT64});
    put_byte(8'h80 | 8'($urandom_range(255)));
    for (int i = 0; i < 7; i++) put_byte(8'($urandom_range(255)));
    for (int i = 0; i < 4; i++) put_byte(8'($urandom_range(255)));
    for (int i = 0; i < TAIL_BYTES; i++) put_byte(8'($urandom_range(255)));

    stall_pct <= 0;
    drain();
    repeat (8) @(posedge clk);

    if (fail_count == 0 && results_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_rx_if.sv
hw/rtl/wsd_pl_if.sv
hw/rtl/wsd_in_reg.sv
hw/rtl/wsd_parser.sv
hw/rtl/wsd_out_reg.sv
hw/rtl/websocket_frame_deframer.sv
test/wsd_deframer_checker.sv
test/websocket_frame_deframer_tb.sv
